### src/go_back_n_receiver_defines.svh
// assertion macros for the go-back-n receiver
`ifndef GO_BACK_N_RECEIVER_DEFINES_SVH
`define GO_BACK_N_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define GBN_ASSERT_NOW(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("gbn check failed");

// next-cycle implication, sampled on clk, off during rst
`define GBN_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("gbn check failed");

`endif

### src/gbn_pkg.sv
// shared types and constants of the go-back-n receiver
package gbn_pkg;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] SEQ_FLIP   = 8'h80;
  localparam logic [BYTE_W-1:0] CHECK_GOOD = 8'hFF;
  localparam logic [BYTE_W-1:0] BASE_MAX   = 8'hFF;
  localparam logic [BYTE_W-1:0] ACK_TYPE_RESET = 8'h01;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic take;
    logic load_pay;
    logic load_ack;
    logic rd_clr;
    logic rd_inc;
  } gbn_cmd_t;

  typedef struct packed {
    logic at_check;
    logic pkt_ok;
    logic in_order;
    logic rd_zero;
    logic rd_last;
    logic out_free;
  } gbn_status_t;

endpackage

### src/gbn_if.sv
// item channels: incoming packet bytes and outgoing results
interface gbn_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;

  modport source (output valid, output packet_byte, input ready);
  modport sink (input valid, input packet_byte, output ready);
endinterface

interface gbn_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] ack_sequence;
  logic [7:0] ack_check;
  logic       last_in_run;

  modport source (
    output valid, output result_kind, output payload_byte,
    output ack_sequence, output ack_check, output last_in_run, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte,
    input ack_sequence, input ack_check, input last_in_run, output ready
  );
endinterface

### src/gbn_ctrl.sv
// controller state machine of the go-back-n receiver
`include "go_back_n_receiver_defines.svh"

module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gbn_status_t status,
  output gbn_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_RECV,
    S_FETCH,
    S_EMIT,
    S_ACK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_RECV: begin
        in_ready = !status.at_check || status.out_free;
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (status.at_check) begin
            if (!status.pkt_ok) begin
              cmd.load_ack = 1'b1;
            end else if (status.in_order) begin
              cmd.rd_clr = 1'b1;
              state_next = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.rd_zero) begin
          state_next = S_ACK;
        end else if (status.out_free) begin
          cmd.load_pay = 1'b1;
          if (status.rd_last) begin
            state_next = S_ACK;
          end else begin
            cmd.rd_inc = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_ACK: begin
        if (status.out_free) begin
          cmd.load_ack = 1'b1;
          state_next = S_RECV;
        end
      end
      default: begin
        state_next = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  `GBN_ASSERT_NEXT(a_zero_ends_run, state == S_EMIT && status.rd_zero, state == S_ACK)
  `GBN_ASSERT_NEXT(a_good_starts_run,
    cmd.take && status.at_check && status.pkt_ok && status.in_order, state == S_FETCH)
  `GBN_ASSERT_NOW(a_busy_blocks_input, state != S_RECV, !in_ready)

endmodule

### src/gbn_datapath.sv
// datapath: byte counter, checksum, payload store, base and output register
`include "go_back_n_receiver_defines.svh"

module gbn_datapath
  import gbn_pkg::*;
#(
  parameter int PACKET_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  input  logic [BYTE_W-1:0] packet_byte,
  input  gbn_cmd_t          cmd,
  output gbn_status_t       status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              result_kind,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [BYTE_W-1:0] ack_sequence,
  output logic [BYTE_W-1:0] ack_check,
  output logic              last_in_run
);

  localparam int PAY_BYTES = PACKET_BYTES - 3;
  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam int IDX_W = (PAY_BYTES > 1) ? $clog2(PAY_BYTES) : 1;
  localparam logic [POS_W-1:0] SEQ_POS   = POS_W'(PAY_BYTES);
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PAY_BYTES - 1);

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] held_seq;
  logic [BYTE_W-1:0] base;
  logic [BYTE_W-1:0] ack_type;
  logic [IDX_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] store [PAY_BYTES];

  logic [BYTE_W-1:0] sum_next;
  logic [BYTE_W-1:0] cur_ack_seq;
  logic [BYTE_W:0]   base_inc;

  assign sum_next    = sum + packet_byte;
  assign cur_ack_seq = base ^ SEQ_FLIP;
  assign base_inc    = {1'b0, base} + {{BYTE_W{1'b0}}, 1'b1};

  assign status.at_check = (pos == CHECK_POS);
  assign status.pkt_ok   = (sum_next == CHECK_GOOD);
  assign status.in_order = ({1'b0, held_seq ^ SEQ_FLIP} == base_inc);
  assign status.rd_zero  = (rd_data == '0);
  assign status.rd_last  = (rd_idx == LAST_IDX);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take && pos < SEQ_POS) begin
      store[pos[IDX_W-1:0]] <= packet_byte;
    end
    rd_data <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      sum       <= '0;
      held_seq  <= '0;
      base      <= '0;
      ack_type  <= ACK_TYPE_RESET;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ack_type <= cfg_wr_data;
      end
      if (cmd.take) begin
        if (status.at_check) begin
          pos <= '0;
          sum <= '0;
          if (status.pkt_ok && status.in_order && base != BASE_MAX) begin
            base <= base_inc[BYTE_W-1:0];
          end
        end else begin
          pos <= pos + 1'b1;
          sum <= sum_next;
          if (pos == SEQ_POS) begin
            held_seq <= packet_byte;
          end
        end
      end
      if (cmd.rd_clr) begin
        rd_idx <= '0;
      end else if (cmd.rd_inc) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmd.load_pay || cmd.load_ack) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pay) begin
      result_kind  <= KIND_PAYLOAD;
      payload_byte <= rd_data;
      ack_sequence <= '0;
      ack_check    <= '0;
      last_in_run  <= 1'b0;
    end else if (cmd.load_ack) begin
      result_kind  <= KIND_ACK;
      payload_byte <= '0;
      ack_sequence <= cur_ack_seq;
      ack_check    <= ~(cur_ack_seq + ack_type);
      last_in_run  <= 1'b1;
    end
  end

  `GBN_ASSERT_NEXT(a_ack_is_last, cmd.load_ack, out_valid && last_in_run && result_kind)
  `GBN_ASSERT_NEXT(a_pos_steps, cmd.take && !status.at_check, pos != '0)
  `GBN_ASSERT_NEXT(a_base_monotonic, 1'b1, base >= $past(base))

endmodule

### src/go_back_n_receiver.sv
// go-back-n receiver: the payload of a good in-order packet is delivered up to a zero byte,
// each byte read from the store, then loaded into the output register; its ack follows;
// a byte is taken each cycle while a packet arrives, save while a run is delivered or the
// output is busy at the checksum byte; a corrupt packet is acked the cycle after that byte
// rst (synchronous) clears counters, sum, base and output valid; ack type resets to 1;
// the payload store is not cleared
module go_back_n_receiver
  import gbn_pkg::*;
#(
  parameter int PACKET_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  gbn_byte_if.sink          packet_ch,
  gbn_result_if.source      result_ch
);

  gbn_cmd_t    cmd;
  gbn_status_t status;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (packet_ch.valid),
    .in_ready (packet_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .packet_byte  (packet_ch.packet_byte),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (result_ch.ready),
    .out_valid    (result_ch.valid),
    .result_kind  (result_ch.result_kind),
    .payload_byte (result_ch.payload_byte),
    .ack_sequence (result_ch.ack_sequence),
    .ack_check    (result_ch.ack_check),
    .last_in_run  (result_ch.last_in_run)
  );

endmodule
